// ----- rtl/srts_pkg.sv -----
// ----------------------------------------------------------------------------
// srts_pkg
// Shared types, sizes and codes for the sensor reading table with statistics.
// ----------------------------------------------------------------------------
`default_nettype none

package srts_pkg;

  // Table size and derived widths
  localparam int MAX_ENTRIES = 4;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SUM_W       = 16 + $clog2(MAX_ENTRIES);
  localparam int DIV_CNT_W   = $clog2(SUM_W + 1);

  // Report type accepted for an update, and start value of the minimum
  localparam logic [7:0]         ACCEPTED_TYPE = 8'd2;
  localparam logic signed [15:0] MIN_START     = 16'sd1000;

  // Action codes
  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_STATS  = 2'd1;
  localparam logic [1:0] ACT_ENTRY  = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_IGNORED = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_RANGE   = 3'd4;

  // Input word
  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         msg_type;
    logic [31:0]        sensor_id;
    logic signed [15:0] reading;
    logic [7:0]         entry_index;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [2:0]         status;
    logic signed [15:0] minimum;
    logic signed [15:0] average;
    logic [31:0]        entry_id;
    logic signed [15:0] entry_reading;
  } out_word_t;

  // One table entry
  typedef struct packed {
    logic [31:0]        id;
    logic signed [15:0] reading;
  } entry_t;

  // Table memory access
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Divider start request
  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ----- rtl/srts_mem.sv -----
// ----------------------------------------------------------------------------
// srts_mem
// Entry table: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module srts_mem
  import srts_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_req_t req,
  output entry_t        rdata
);

  entry_t mem [MAX_ENTRIES];
  entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/srts_div.sv -----
// ----------------------------------------------------------------------------
// srts_div
// Radix-2 restoring divider: signed sum by entry count, truncating toward 0.
// ----------------------------------------------------------------------------
`default_nettype none

module srts_div
  import srts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output logic          done,
  output logic signed [15:0] quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0]     quo_r;
  logic [CNT_W-1:0]     rem_r;
  logic [CNT_W-1:0]     div_r;
  logic                 neg_r;

  logic [CNT_W:0]   trial;
  logic             fits;
  logic [CNT_W:0]   diff;
  logic [SUM_W-1:0] mag;
  logic [SUM_W-1:0] signed_quo;

  // magnitude of the dividend
  assign mag = req.dividend[SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;

  // one quotient bit per cycle
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign fits  = (trial >= {1'b0, div_r});
  assign diff  = trial - {1'b0, div_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= mag;
      rem_r <= '0;
      div_r <= req.divisor;
      neg_r <= req.dividend[SUM_W-1];
      cnt_r <= DIV_CNT_W'(SUM_W - 1);
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], fits};
      rem_r <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // restore the sign; the mean always fits in 16 bits
  assign signed_quo = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient   = signed_quo[15:0];
  assign done       = done_r;

endmodule

`default_nettype wire

// ----- rtl/sensor_reading_table_stats.sv -----
// ----------------------------------------------------------------------------
// sensor_reading_table_stats
// Keyed table of sensor readings with update, min/average stats and indexed
// read, held in a one-port-read synchronous memory.
//
//   channel | ports                        | word
//   --------+------------------------------+-----------
//   input   | in_valid  in_ready  in_data  | in_word_t
//   result  | out_valid out_ready out_data | out_word_t
//
// One word is worked on at a time. Each entry visited is a memory read (S_READ),
// then a compare/accumulate (S_EVAL). Update searches up to a hit or the last
// entry; stats visits every entry, then the divider (one quotient bit per
// cycle); read entry visits one. Ignored, empty-table and out-of-range words and
// an append to an empty table skip the search. The result register frees the
// engine once loaded. Reset (rst_n low, synchronous) empties the table; entry
// contents are not cleared. A stalled result holds the engine in its last state.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_reading_table_stats
  import srts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_READ     = 6'b000010,
    S_EVAL     = 6'b000100,
    S_DIV_WAIT = 6'b001000,
    S_DONE     = 6'b010000,
    S_SPARE    = 6'b100000
  } state_t;

  state_t                  state_r,     state_nxt;
  logic [CNT_W-1:0]        count_r,     count_nxt;
  logic [CNT_W-1:0]        ptr_r,       ptr_nxt;
  in_word_t                item_r,      item_nxt;
  logic signed [15:0]      min_r,       min_nxt;
  logic signed [SUM_W-1:0] sum_r,       sum_nxt;
  out_word_t               res_r,       res_nxt;
  out_word_t               out_r,       out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  mem_req_t           mem_req;
  entry_t             mem_rdata;
  div_req_t           div_req;
  logic               div_done;
  logic signed [15:0] div_quo;

  logic               in_acc;
  logic [CNT_W-1:0]   ptr_inc;
  logic               last_entry;
  logic signed [SUM_W-1:0] sum_add;
  logic               out_load;

  srts_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  srts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign ptr_inc    = ptr_r + CNT_W'(1);
  assign last_entry = (ptr_inc == count_r);
  assign sum_add    = sum_r + SUM_W'(mem_rdata.reading);
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // main sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    item_nxt      = item_r;
    min_nxt       = min_r;
    sum_nxt       = sum_r;
    res_nxt       = res_r;
    mem_req       = '0;
    div_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_nxt = in_data;
          res_nxt  = '0;
          ptr_nxt  = '0;
          min_nxt  = MIN_START;
          sum_nxt  = '0;
          case (in_data.action)
            ACT_UPDATE: begin
              if (in_data.msg_type != ACCEPTED_TYPE) begin
                res_nxt.status = ST_IGNORED;
                state_nxt      = S_DONE;
              end else if (count_r == '0) begin
                // empty table: append at slot 0 at once
                mem_req.we            = 1'b1;
                mem_req.waddr         = '0;
                mem_req.wdata.id      = in_data.sensor_id;
                mem_req.wdata.reading = in_data.reading;
                count_nxt             = CNT_W'(1);
                res_nxt.status        = ST_OK;
                state_nxt             = S_DONE;
              end else begin
                state_nxt = S_READ;
              end
            end
            ACT_STATS: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_READ;
              end
            end
            ACT_ENTRY: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
                state_nxt      = S_DONE;
              end else if (in_data.entry_index >= 8'(count_r)) begin
                res_nxt.status = ST_RANGE;
                state_nxt      = S_DONE;
              end else begin
                ptr_nxt   = in_data.entry_index[CNT_W-1:0];
                state_nxt = S_READ;
              end
            end
            default: begin
              res_nxt.status = ST_IGNORED;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = ptr_r[IDX_W-1:0];
        state_nxt     = S_EVAL;
      end

      S_EVAL: begin
        case (item_r.action)
          ACT_UPDATE: begin
            if (mem_rdata.id == item_r.sensor_id) begin
              // hit: overwrite the reading in place
              mem_req.we            = 1'b1;
              mem_req.waddr         = ptr_r[IDX_W-1:0];
              mem_req.wdata.id      = item_r.sensor_id;
              mem_req.wdata.reading = item_r.reading;
              res_nxt.status        = ST_OK;
              state_nxt             = S_DONE;
            end else if (last_entry) begin
              // miss: append if room remains
              if (count_r < CNT_W'(MAX_ENTRIES)) begin
                mem_req.we            = 1'b1;
                mem_req.waddr         = count_r[IDX_W-1:0];
                mem_req.wdata.id      = item_r.sensor_id;
                mem_req.wdata.reading = item_r.reading;
                count_nxt             = count_r + CNT_W'(1);
                res_nxt.status        = ST_OK;
              end else begin
                res_nxt.status = ST_FULL;
              end
              state_nxt = S_DONE;
            end else begin
              ptr_nxt   = ptr_inc;
              state_nxt = S_READ;
            end
          end
          ACT_STATS: begin
            if (mem_rdata.reading < min_r) begin
              min_nxt = mem_rdata.reading;
            end
            sum_nxt = sum_add;
            if (last_entry) begin
              div_req.start    = 1'b1;
              div_req.dividend = sum_add;
              div_req.divisor  = count_r;
              state_nxt        = S_DIV_WAIT;
            end else begin
              ptr_nxt   = ptr_inc;
              state_nxt = S_READ;
            end
          end
          default: begin
            // read entry
            res_nxt.status        = ST_OK;
            res_nxt.entry_id      = mem_rdata.id;
            res_nxt.entry_reading = mem_rdata.reading;
            state_nxt             = S_DONE;
          end
        endcase
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          res_nxt.status  = ST_OK;
          res_nxt.minimum = min_r;
          res_nxt.average = div_quo;
          state_nxt       = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    item_r <= item_nxt;
    min_r  <= min_nxt;
    sum_r  <= sum_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // table never grows past its size
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table size");

  // table grows by at most one entry per word
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("entry count jumped");

  // writes only come from idle append or evaluation
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_IDLE || state_r == S_EVAL))
    else $error("table write outside update");

  // divider finishes only while waited on
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_WAIT))
    else $error("divider done without request");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: sensor reading table with statistics
// Drives update, stats and read-entry words into sensor_reading_table_stats
// through its valid/ready channels under random idling on both sides. A
// tracker keeps its own copy of the table, predicts every result word and
// compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srts_pkg::*;

  // Action 3 has no package name; the block answers it as ignored
  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int         PHASE_WORDS  = 534;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         DRAIN_CYCLES = 60;

  // Table tracker: predicted table contents and the results still awaited
  class reading_table_tracker;
    logic [31:0]        ids [MAX_ENTRIES];
    logic signed [15:0] vals [MAX_ENTRIES];
    int                 count = 0;
    out_word_t          awaited[$];
    int                 errors = 0;
    int                 results_seen = 0;
    int                 hits = 0;
    int                 appends = 0;
    int                 refusals = 0;
    int                 stats_words = 0;
    int                 range_words = 0;

    // Work out the result of an accepted input word and update the table
    function void note_accepted(in_word_t w);
      out_word_t          e;
      int                 i;
      int                 sum;
      logic signed [15:0] low;
      bit                 hit;
      e = '0;
      case (w.action)
        ACT_UPDATE: begin
          if (w.msg_type != ACCEPTED_TYPE) begin
            e.status = ST_IGNORED;
          end else begin
            hit = 1'b0;
            for (i = 0; i < count; i++) begin
              if (!hit && ids[i] == w.sensor_id) begin
                vals[i] = w.reading;
                hit = 1'b1;
              end
            end
            if (hit) begin
              hits++;
            end else if (count < MAX_ENTRIES) begin
              ids[count] = w.sensor_id;
              vals[count] = w.reading;
              count++;
              appends++;
            end else begin
              e.status = ST_FULL;
              refusals++;
            end
          end
        end
        ACT_STATS: begin
          stats_words++;
          if (count == 0) begin
            e.status = ST_EMPTY;
          end else begin
            low = MIN_START;
            sum = 0;
            for (i = 0; i < count; i++) begin
              if (vals[i] < low) low = vals[i];
              sum += vals[i];
            end
            e.minimum = low;
            // int division truncates toward zero
            e.average = 16'(sum / count);
          end
        end
        ACT_ENTRY: begin
          if (count == 0) begin
            e.status = ST_EMPTY;
          end else if (w.entry_index >= count) begin
            e.status = ST_RANGE;
            range_words++;
          end else begin
            e.entry_id = ids[w.entry_index];
            e.entry_reading = vals[w.entry_index];
          end
        end
        default: begin
          e.status = ST_IGNORED;
        end
      endcase
      awaited.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("%0t ns mismatch %s: got %h expected %h", $time, what, got, want);
    endtask

    // Compare one result word with the oldest prediction
    task check_result(out_word_t r);
      out_word_t e;
      results_seen++;
      if (awaited.size() == 0) begin
        report("result word with nothing awaited", 32'(r.status), 32'd0);
        return;
      end
      e = awaited.pop_front();
      if (r.status !== e.status) report("status", 32'(r.status), 32'(e.status));
      if (r.minimum !== e.minimum) report("minimum", 32'(r.minimum), 32'(e.minimum));
      if (r.average !== e.average) report("average", 32'(r.average), 32'(e.average));
      if (r.entry_id !== e.entry_id) report("entry_id", r.entry_id, e.entry_id);
      if (r.entry_reading !== e.entry_reading) begin
        report("entry_reading", 32'(r.entry_reading), 32'(e.entry_reading));
      end
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  reading_table_tracker tracker = new();

  int send_idle_pct = 12;
  int recv_idle_pct = 62;
  bit hold_go = 1'b0;
  int hold_left = 0;
  int words_sent = 0;
  int directed_words = 0;

  sensor_reading_table_stats dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 20 ns clock
  always #10 clk = ~clk;

  // Receiver: random stalls, or a long hold-off when asked for
  always @(negedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_result(out_data);
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one word; returns at the edge where it is taken. The caller either
  // sends again or lowers valid at the next falling edge.
  task automatic send_word(in_word_t w);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_accepted(w);
    words_sent++;
  endtask

  // Stop offering and wait for every awaited result
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic in_word_t word_of(logic [1:0] act, logic [7:0] mtype, logic [31:0] id,
                                       logic signed [15:0] rd, logic [7:0] idx);
    in_word_t w;
    w.action = act;
    w.msg_type = mtype;
    w.sensor_id = id;
    w.reading = rd;
    w.entry_index = idx;
    return w;
  endfunction

  // Random word: mostly accepted updates on known ids, then stats and reads
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    w.action = 2'($urandom);
    w.msg_type = 8'($urandom);
    w.sensor_id = $urandom;
    w.reading = 16'($urandom);
    w.entry_index = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      w.action = ACT_UPDATE;
      if ($urandom_range(0, 9) != 0) w.msg_type = ACCEPTED_TYPE;
      if (tracker.count > 0 && $urandom_range(0, 3) != 0) begin
        w.sensor_id = tracker.ids[$urandom_range(0, tracker.count - 1)];
      end
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 5))
          0: w.reading = -16'sd32768;
          1: w.reading = 16'sd32767;
          2: w.reading = 16'sd999;
          3: w.reading = 16'sd1000;
          4: w.reading = 16'sd1001;
          default: w.reading = -16'sd1;
        endcase
      end
    end else if (pick < 75) begin
      w.action = ACT_STATS;
    end else if (pick < 95) begin
      w.action = ACT_ENTRY;
      if ($urandom_range(0, 3) != 0) w.entry_index = 8'($urandom_range(0, MAX_ENTRIES));
    end else begin
      w.action = ACT_UNUSED;
    end
    return w;
  endfunction

  // Main sequence
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, ignored words, growth to full, refusal, cap
    send_word(word_of(ACT_STATS, 8'd0, 32'h0, 16'sd0, 8'd0));
    send_word(word_of(ACT_ENTRY, 8'd0, 32'h0, 16'sd0, 8'd0));
    send_word(word_of(ACT_UPDATE, 8'd0, 32'h1, 16'sd7, 8'd0));
    send_word(word_of(ACT_UPDATE, 8'hFF, 32'h1, 16'sd7, 8'd0));
    send_word(word_of(ACT_UNUSED, ACCEPTED_TYPE, 32'h5, 16'sd1, 8'd0));
    send_word(word_of(ACT_UPDATE, ACCEPTED_TYPE, 32'h0, -16'sd32768, 8'd0));
    send_word(word_of(ACT_STATS, 8'd0, 32'h0, 16'sd0, 8'd0));
    send_word(word_of(ACT_ENTRY, 8'd0, 32'h0, 16'sd0, 8'd0));
    send_word(word_of(ACT_ENTRY, 8'd0, 32'h0, 16'sd0, 8'd1));
    send_word(word_of(ACT_UPDATE, ACCEPTED_TYPE, 32'hFFFF_FFFF, 16'sd32767, 8'd0));
    send_word(word_of(ACT_UPDATE, ACCEPTED_TYPE, 32'h0, -16'sd3, 8'd0));
    send_word(word_of(ACT_STATS, 8'd0, 32'h0, 16'sd0, 8'd0));
    send_word(word_of(ACT_UPDATE, ACCEPTED_TYPE, 32'h1234_5678, 16'sd1000, 8'd0));
    send_word(word_of(ACT_UPDATE, ACCEPTED_TYPE, 32'hA5A5_A5A5, -16'sd32768, 8'd0));
    send_word(word_of(ACT_UPDATE, ACCEPTED_TYPE, 32'hDEAD_BEEF, 16'sd5, 8'd0));
    send_word(word_of(ACT_STATS, 8'd0, 32'h0, 16'sd0, 8'd0));
    send_word(word_of(ACT_ENTRY, 8'd0, 32'h0, 16'sd0, 8'd3));
    send_word(word_of(ACT_ENTRY, 8'd0, 32'h0, 16'sd0, 8'd4));
    send_word(word_of(ACT_ENTRY, 8'd0, 32'h0, 16'sd0, 8'd255));
    // All readings above the start value: minimum stays at 1000
    send_word(word_of(ACT_UPDATE, ACCEPTED_TYPE, 32'h0, 16'sd32767, 8'd0));
    send_word(word_of(ACT_UPDATE, ACCEPTED_TYPE, 32'hFFFF_FFFF, 16'sd32767, 8'd0));
    send_word(word_of(ACT_UPDATE, ACCEPTED_TYPE, 32'h1234_5678, 16'sd32767, 8'd0));
    send_word(word_of(ACT_UPDATE, ACCEPTED_TYPE, 32'hA5A5_A5A5, 16'sd32767, 8'd0));
    send_word(word_of(ACT_STATS, 8'd0, 32'h0, 16'sd0, 8'd0));
    directed_words = words_sent;
    wait_drained();

    // Random: three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 62 : 0;
      recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 12 : 0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // long receiver hold-off while words keep coming
        if (phase == 0 && n == 100) hold_go = 1'b1;
        if (phase == 2 && n == 200) hold_go = 1'b1;
        send_word(random_word());
        // sender pause until the block has drained
        if (phase == 1 && n == 300) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.awaited.size() != 0) begin
      tracker.report("results never arrived", 32'(tracker.awaited.size()), 32'd0);
    end

    $display("Sent %0d words (%0d directed), %0d result words compared",
             words_sent, directed_words, tracker.results_seen);
    $display("Table hits %0d, appends %0d, full refusals %0d, stats %0d, out-of-range reads %0d",
             tracker.hits, tracker.appends, tracker.refusals, tracker.stats_words,
             tracker.range_words);
    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/srts_pkg.sv
rtl/srts_mem.sv
rtl/srts_div.sv
rtl/sensor_reading_table_stats.sv
sim/tb.sv
